### rtl/mmad_pkg.sv
package mmad_pkg;

  typedef enum logic [4:0] {
    TGT_RAM     = 5'd0,
    TGT_BASIC   = 5'd1,
    TGT_PIA     = 5'd2,
    TGT_ACIA    = 5'd3,
    TGT_SCREEN  = 5'd4,
    TGT_COLOR   = 5'd5,
    TGT_STAT540 = 5'd6,
    TGT_HIRES   = 5'd7,
    TGT_AKBD    = 5'd8,
    TGT_XRAMD   = 5'd9,
    TGT_XRAME   = 5'd10,
    TGT_KBD     = 5'd11,
    TGT_KERNEL  = 5'd12,
    TGT_TAPE    = 5'd13,
    TGT_XRAMF   = 5'd14,
    TGT_CTL6    = 5'd15,
    TGT_CTL5    = 5'd16,
    TGT_NONE    = 5'd17
  } mmad_target_e;

  typedef enum logic [1:0] {
    SND_NONE = 2'd0,
    SND_542  = 2'd1,
    SND_600  = 2'd2
  } mmad_sound_e;

  typedef enum logic [2:0] {
    REG_RAM_TOP    = 3'd0,
    REG_FEATURES   = 3'd1,
    REG_MODE       = 3'd2,
    REG_SCREEN_WIN = 3'd3,
    REG_COLOR_WIN  = 3'd4,
    REG_ROM_BOTTOM = 3'd5,
    REG_TAPE_BASE  = 3'd6
  } mmad_reg_e;

  // Feature enable bit positions.
  localparam int unsigned FEAT_BASIC = 0;
  localparam int unsigned FEAT_FLOPPY = 1;
  localparam int unsigned FEAT_VIDEO = 2;
  localparam int unsigned FEAT_COLOR = 3;
  localparam int unsigned FEAT_AKBD = 4;
  localparam int unsigned FEAT_XRAMD = 5;
  localparam int unsigned FEAT_XRAME = 6;
  localparam int unsigned FEAT_XRAMF = 7;
  localparam int unsigned FEAT_CTL6 = 8;
  localparam int unsigned FEAT_CTL5 = 9;

  // Hires and sound mode codes; the reserved code 3 acts as none.
  // The hires codes are named after the window each one maps.
  localparam logic [1:0] HIRES_E000 = 2'd1;
  localparam logic [1:0] HIRES_8000 = 2'd2;
  localparam logic [1:0] SOUND_542B = 2'd1;
  localparam logic [1:0] SOUND_600 = 2'd2;

  localparam logic [15:0] RAM_TOP_RST = 16'h9FFF;
  localparam logic [9:0] FEATURES_RST = 10'h001;
  localparam logic [15:0] ROM_BOTTOM_RST = 16'hF000;
  localparam logic [15:0] TAPE_BASE_RST = 16'hF000;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef struct packed {
    logic [15:0] ram_top;
    logic [9:0]  features;
    logic [4:0]  mode;
    logic [15:0] scr_lo;
    logic [15:0] scr_hi;
    logic [15:0] col_lo;
    logic [15:0] col_hi;
    logic [15:0] rom_bottom;
    logic [15:0] tape_base;
  } mmad_cfg_t;

  typedef struct packed {
    logic         cmd;
    logic [15:0]  address;
    logic [7:0]   write_data;
  } mmad_req_t;

  typedef struct packed {
    mmad_sound_e  sound_side;
    logic [7:0]   data;
    logic [15:0]  offset;
    mmad_target_e target;
  } mmad_res_t;

endpackage

### rtl/memory_map_access_decoder_core.sv
// Bus access decoder: classifies one CPU read or write into a target region,
// an offset into that region, a data byte and a sound side-effect flag.
// Input beats arrive on the s_axis channel: tuser carries the access kind
// (0 read, 1 write), tdata the address and the write byte. Results leave on
// m_axis as one 32-bit beat per input beat, in order.
// The block is a two-register pipeline: an accepted beat is held in the
// input register, decoded by one pass of compare logic from the live
// configuration, and captured in the result register, which offers it
// on m_axis; one beat per cycle is sustained when the receiver keeps
// tready high.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; after that s_axis_tready drops until
// the result moves on.
// Reset empties both stages and loads the configuration registers with
// their defaults. The configuration channel is always ready and must only be
// written while no beats are in flight.
module memory_map_access_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [23:0]                       s_axis_tdata,  // address[15:0], write_data[23:16]
  input  logic                              s_axis_tuser,  // cmd[0]
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // target[4:0], offset[20:5], data[28:21], sound_side[30:29], zero[31]
  output logic [31:0]                       m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mmad_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [mmad_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  mmad_pkg::mmad_cfg_t cfg;
  mmad_pkg::mmad_req_t req_q, req_d;
  mmad_pkg::mmad_res_t res_q, res_d;
  logic                req_valid_q, req_valid_d;
  logic                res_valid_q, res_valid_d;
  logic                in_fire, res_load;

  assign cfg_ready_o = 1'b1;

  mmad_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mmad_decode u_decode (
    .req_i (req_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  assign res_load      = !res_valid_q || m_axis_tready;
  assign s_axis_tready = !req_valid_q || res_load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    req_d = req_q;
    if (in_fire) begin
      req_d.cmd        = s_axis_tuser;
      req_d.address    = s_axis_tdata[15:0];
      req_d.write_data = s_axis_tdata[23:16];
    end
    req_valid_d = in_fire || (req_valid_q && !res_load);
    res_valid_d = res_load ? req_valid_q : res_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

  // A sound side effect only comes with a keyboard page write.
  a_sound_kbd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.sound_side != mmad_pkg::SND_NONE)
      |-> (res_q.target == mmad_pkg::TGT_KBD))
    else $error("sound side effect without keyboard target");

  // Extra RAM banks and the kernel see only a 4 KiB offset.
  a_bank_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && (res_q.target == mmad_pkg::TGT_XRAMD || res_q.target == mmad_pkg::TGT_XRAME
      || res_q.target == mmad_pkg::TGT_XRAMF || res_q.target == mmad_pkg::TGT_KERNEL))
      |-> (res_q.offset[15:12] == 4'h0))
    else $error("bank offset out of range");

  // A held input beat moves into the result stage as soon as that stage frees up.
  a_pipe_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_q && res_load) |=> res_valid_q)
    else $error("pipeline lost a beat");

endmodule

### rtl/mmad_cfg_regs.sv
module mmad_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  input  logic [mmad_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [mmad_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output mmad_pkg::mmad_cfg_t                   cfg_o
);

  mmad_pkg::mmad_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (mmad_pkg::mmad_reg_e'(cfg_index_i))
        mmad_pkg::REG_RAM_TOP:    cfg_d.ram_top = cfg_data_i[15:0];
        mmad_pkg::REG_FEATURES:   cfg_d.features = cfg_data_i[9:0];
        mmad_pkg::REG_MODE:       cfg_d.mode = cfg_data_i[4:0];
        mmad_pkg::REG_SCREEN_WIN: begin
          cfg_d.scr_lo = cfg_data_i[15:0];
          cfg_d.scr_hi = cfg_data_i[31:16];
        end
        mmad_pkg::REG_COLOR_WIN: begin
          cfg_d.col_lo = cfg_data_i[15:0];
          cfg_d.col_hi = cfg_data_i[31:16];
        end
        mmad_pkg::REG_ROM_BOTTOM: cfg_d.rom_bottom = cfg_data_i[15:0];
        mmad_pkg::REG_TAPE_BASE:  cfg_d.tape_base = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ram_top    <= mmad_pkg::RAM_TOP_RST;
      cfg_q.features   <= mmad_pkg::FEATURES_RST;
      cfg_q.mode       <= '0;
      cfg_q.scr_lo     <= '0;
      cfg_q.scr_hi     <= '0;
      cfg_q.col_lo     <= '0;
      cfg_q.col_hi     <= '0;
      cfg_q.rom_bottom <= mmad_pkg::ROM_BOTTOM_RST;
      cfg_q.tape_base  <= mmad_pkg::TAPE_BASE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/mmad_decode.sv
module mmad_decode (
  input  mmad_pkg::mmad_req_t req_i,
  input  mmad_pkg::mmad_cfg_t cfg_i,
  output mmad_pkg::mmad_res_t res_o
);

  logic [15:0] a;
  logic        rd;
  logic [9:0]  f;
  logic [1:0]  hires;
  logic [1:0]  sound;
  logic [16:0] tape_end;
  logic        hit_basic, hit_pia, hit_acia, hit_xd, hit_xe, hit_xf, page_df;
  logic        hit_tape, hit_scr, hit_col;
  mmad_pkg::mmad_target_e vid_tgt;
  mmad_pkg::mmad_target_e tgt;
  logic [15:0] off;
  logic [1:0]  snd;

  assign a     = req_i.address;
  assign rd    = !req_i.cmd;
  assign f     = cfg_i.features;
  assign hires = cfg_i.mode[2:1];
  assign sound = cfg_i.mode[4:3];

  // The tape page does not wrap past the top of the address space.
  assign tape_end  = {1'b0, cfg_i.tape_base} + 17'h000FF;
  assign hit_tape  = (a >= cfg_i.tape_base) && ({1'b0, a} <= tape_end);
  assign hit_scr   = (a >= cfg_i.scr_lo) && (a <= cfg_i.scr_hi);
  assign hit_col   = (a >= cfg_i.col_lo) && (a <= cfg_i.col_hi);
  assign hit_basic = (a >= 16'hA000) && (a <= 16'hBFFF);
  assign hit_pia   = (a >= 16'hC000) && (a <= 16'hC003);
  assign hit_acia  = (a >= 16'hC010) && (a <= 16'hC011);
  assign hit_xd    = (a[15:12] == 4'hD);
  assign hit_xe    = (a[15:12] == 4'hE);
  assign hit_xf    = (a[15:12] == 4'hF);
  assign page_df   = (a[15:8] == 8'hDF);

  always_comb begin
    vid_tgt = mmad_pkg::TGT_NONE;
    if (f[mmad_pkg::FEAT_VIDEO]) begin
      priority if (hit_scr) begin
        vid_tgt = mmad_pkg::TGT_SCREEN;
      end else if (f[mmad_pkg::FEAT_COLOR] && hit_col) begin
        vid_tgt = mmad_pkg::TGT_COLOR;
      end else if (f[mmad_pkg::FEAT_COLOR] && rd && cfg_i.mode[0] && a == 16'hDE00) begin
        vid_tgt = mmad_pkg::TGT_STAT540;
      end else if (hires == mmad_pkg::HIRES_E000 && a >= 16'hE000 && a <= 16'hE7FF) begin
        vid_tgt = mmad_pkg::TGT_HIRES;
      end else if (hires == mmad_pkg::HIRES_8000 && a >= 16'h8000 && a <= 16'h9FFF) begin
        vid_tgt = mmad_pkg::TGT_HIRES;
      end else begin
        vid_tgt = mmad_pkg::TGT_NONE;
      end
    end
  end

  always_comb begin
    tgt = mmad_pkg::TGT_NONE;
    off = a;
    snd = mmad_pkg::SND_NONE;
    if (rd) begin
      priority if (a <= cfg_i.ram_top) begin
        tgt = mmad_pkg::TGT_RAM;
      end else if (f[mmad_pkg::FEAT_BASIC] && hit_basic) begin
        tgt = mmad_pkg::TGT_BASIC;
        off = a - 16'hA000;
      end else if (f[mmad_pkg::FEAT_FLOPPY] && hit_pia) begin
        tgt = mmad_pkg::TGT_PIA;
      end else if (f[mmad_pkg::FEAT_FLOPPY] && hit_acia) begin
        tgt = mmad_pkg::TGT_ACIA;
      end else if (vid_tgt != mmad_pkg::TGT_NONE) begin
        tgt = vid_tgt;
      end else if (f[mmad_pkg::FEAT_AKBD] && a == 16'hDF01) begin
        tgt = mmad_pkg::TGT_AKBD;
      end else if (f[mmad_pkg::FEAT_XRAMD] && hit_xd) begin
        tgt = mmad_pkg::TGT_XRAMD;
        off = {4'h0, a[11:0]};
      end else if (f[mmad_pkg::FEAT_XRAME] && hit_xe) begin
        tgt = mmad_pkg::TGT_XRAME;
        off = {4'h0, a[11:0]};
      end else if (page_df) begin
        tgt = mmad_pkg::TGT_KBD;
      end else if (a >= cfg_i.rom_bottom) begin
        // Kernel offset is relative to f000 even when the image starts lower.
        tgt = mmad_pkg::TGT_KERNEL;
        off = {4'h0, a[11:0]};
      end else if (hit_tape) begin
        tgt = mmad_pkg::TGT_TAPE;
      end else if (f[mmad_pkg::FEAT_XRAMF] && hit_xf) begin
        tgt = mmad_pkg::TGT_XRAMF;
        off = {4'h0, a[11:0]};
      end else begin
        tgt = mmad_pkg::TGT_NONE;
      end
    end else begin
      priority if (a <= cfg_i.ram_top) begin
        tgt = mmad_pkg::TGT_RAM;
      end else if (f[mmad_pkg::FEAT_FLOPPY] && hit_pia) begin
        tgt = mmad_pkg::TGT_PIA;
      end else if (f[mmad_pkg::FEAT_FLOPPY] && hit_acia) begin
        tgt = mmad_pkg::TGT_ACIA;
      end else if (vid_tgt != mmad_pkg::TGT_NONE) begin
        tgt = vid_tgt;
      end else if (f[mmad_pkg::FEAT_XRAMD] && hit_xd) begin
        tgt = mmad_pkg::TGT_XRAMD;
        off = {4'h0, a[11:0]};
      end else if (f[mmad_pkg::FEAT_XRAME] && hit_xe) begin
        tgt = mmad_pkg::TGT_XRAME;
        off = {4'h0, a[11:0]};
      end else if (f[mmad_pkg::FEAT_CTL6] && a == 16'hD800) begin
        tgt = mmad_pkg::TGT_CTL6;
      end else if (f[mmad_pkg::FEAT_CTL5] && a == 16'hDE00) begin
        tgt = mmad_pkg::TGT_CTL5;
      end else if (page_df) begin
        // Keyboard page writes may also drive a sound DAC or tone.
        tgt = mmad_pkg::TGT_KBD;
        if (sound == mmad_pkg::SOUND_600) begin
          snd = mmad_pkg::SND_600;
        end else if (sound == mmad_pkg::SOUND_542B && a == 16'hDF01) begin
          snd = mmad_pkg::SND_542;
        end
      end else if (hit_tape) begin
        tgt = mmad_pkg::TGT_TAPE;
      end else if (f[mmad_pkg::FEAT_XRAMF] && hit_xf) begin
        tgt = mmad_pkg::TGT_XRAMF;
        off = {4'h0, a[11:0]};
      end else begin
        tgt = mmad_pkg::TGT_NONE;
      end
    end
  end

  always_comb begin
    res_o.target     = tgt;
    res_o.offset     = off;
    res_o.sound_side = mmad_pkg::mmad_sound_e'(snd);
    if (!rd) begin
      res_o.data = req_i.write_data;
    end else if (tgt == mmad_pkg::TGT_NONE) begin
      res_o.data = a[15:8];
    end else begin
      res_o.data = 8'h00;
    end
  end

endmodule

### tb/tb_memory_map_access_decoder_core.sv
module tb_memory_map_access_decoder_core;
  import mmad_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTINGS_PER_PHASE = 4;
  localparam int ACCESSES_PER_SETTING = 58;

  typedef struct {
    logic        is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] reg_val;
    logic        wr;
    logic [15:0] addr;
    logic [7:0]  wd;
    logic        known;
    mmad_res_t   res;
  } probe_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;  // address[15:0], write_data[23:16]
  logic        s_axis_tuser;  // cmd[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // target[4:0], offset[20:5], data[28:21], sound_side[30:29], zero[31]
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  mmad_cfg_t   map_cfg;
  mmad_res_t   pending_decodes[$];
  mmad_res_t   want;
  probe_row_t  probe_rows[$];
  int          src_idle_pct;
  int          sink_idle_pct;
  int          error_count;
  int          cycle_count;

  memory_map_access_decoder_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** memory_map_access_decoder_core: FAILED **");
      $finish;
    end
  end

  function automatic logic in_range(logic [15:0] a, logic [15:0] lo, logic [15:0] hi);
    return a >= lo && a <= hi;
  endfunction

  // Screen, color and hires checks shared by both access kinds; only reads
  // see the 540 status byte.
  function automatic mmad_target_e video_target(logic [15:0] a, logic rd);
    if (!map_cfg.features[FEAT_VIDEO]) return TGT_NONE;
    if (in_range(a, map_cfg.scr_lo, map_cfg.scr_hi)) return TGT_SCREEN;
    if (map_cfg.features[FEAT_COLOR]) begin
      if (in_range(a, map_cfg.col_lo, map_cfg.col_hi)) return TGT_COLOR;
      if (rd && map_cfg.mode[0] && a == 16'hDE00) return TGT_STAT540;
    end
    if (map_cfg.mode[2:1] == HIRES_E000 && in_range(a, 16'hE000, 16'hE7FF)) return TGT_HIRES;
    if (map_cfg.mode[2:1] == HIRES_8000 && in_range(a, 16'h8000, 16'h9FFF)) return TGT_HIRES;
    return TGT_NONE;
  endfunction

  function automatic mmad_res_t decode_access(logic wr, logic [15:0] a, logic [7:0] wd);
    mmad_res_t    r;
    mmad_target_e vid;
    logic         tape_hit;
    logic [1:0]   sound;
    r.target = TGT_NONE;
    r.offset = a;
    r.data = 8'h00;
    r.sound_side = SND_NONE;
    sound = map_cfg.mode[4:3];
    vid = video_target(a, !wr);
    // The tape page ends at base + 0xff and does not wrap past the top.
    tape_hit = a >= map_cfg.tape_base && {1'b0, a} <= {1'b0, map_cfg.tape_base} + 17'h0FF;
    if (a <= map_cfg.ram_top) begin
      r.target = TGT_RAM;
    end else if (!wr && map_cfg.features[FEAT_BASIC] && in_range(a, 16'hA000, 16'hBFFF)) begin
      r.target = TGT_BASIC;
      r.offset = a - 16'hA000;
    end else if (map_cfg.features[FEAT_FLOPPY] && in_range(a, 16'hC000, 16'hC003)) begin
      r.target = TGT_PIA;
    end else if (map_cfg.features[FEAT_FLOPPY] && in_range(a, 16'hC010, 16'hC011)) begin
      r.target = TGT_ACIA;
    end else if (vid != TGT_NONE) begin
      r.target = vid;
    end else if (!wr && map_cfg.features[FEAT_AKBD] && a == 16'hDF01) begin
      r.target = TGT_AKBD;
    end else if (map_cfg.features[FEAT_XRAMD] && in_range(a, 16'hD000, 16'hDFFF)) begin
      r.target = TGT_XRAMD;
      r.offset = a & 16'h0FFF;
    end else if (map_cfg.features[FEAT_XRAME] && in_range(a, 16'hE000, 16'hEFFF)) begin
      r.target = TGT_XRAME;
      r.offset = a & 16'h0FFF;
    end else if (wr && map_cfg.features[FEAT_CTL6] && a == 16'hD800) begin
      r.target = TGT_CTL6;
    end else if (wr && map_cfg.features[FEAT_CTL5] && a == 16'hDE00) begin
      r.target = TGT_CTL5;
    end else if (a[15:8] == 8'hDF) begin
      r.target = TGT_KBD;
      if (wr && sound == SOUND_600) begin
        r.sound_side = SND_600;
      end else if (wr && sound == SOUND_542B && a == 16'hDF01) begin
        r.sound_side = SND_542;
      end
    end else if (!wr && a >= map_cfg.rom_bottom) begin
      r.target = TGT_KERNEL;
      r.offset = (a - 16'hF000) & 16'h0FFF;
    end else if (tape_hit) begin
      r.target = TGT_TAPE;
    end else if (map_cfg.features[FEAT_XRAMF] && a >= 16'hF000) begin
      r.target = TGT_XRAMF;
      r.offset = a & 16'h0FFF;
    end
    if (wr) begin
      r.data = wd;
    end else if (r.target == TGT_NONE) begin
      r.data = a[15:8];
    end
    return r;
  endfunction

  function automatic probe_row_t reg_row(logic [2:0] idx, logic [31:0] val);
    probe_row_t row;
    row = '{is_cfg: 1'b1, reg_idx: idx, reg_val: val, wr: 1'b0, addr: 16'h0000,
            wd: 8'h00, known: 1'b0, res: '0};
    return row;
  endfunction

  function automatic probe_row_t acc_row(logic wr, logic [15:0] a, logic [7:0] wd);
    probe_row_t row;
    row = '{is_cfg: 1'b0, reg_idx: 3'd0, reg_val: 32'h0, wr: wr, addr: a, wd: wd,
            known: 1'b0, res: '0};
    return row;
  endfunction

  function automatic probe_row_t known_row(logic wr, logic [15:0] a, logic [7:0] wd,
                                           mmad_target_e t, logic [15:0] off,
                                           logic [7:0] d, mmad_sound_e snd);
    probe_row_t row;
    row = acc_row(wr, a, wd);
    row.known = 1'b1;
    row.res.target = t;
    row.res.offset = off;
    row.res.data = d;
    row.res.sound_side = snd;
    return row;
  endfunction

  // Addresses lean toward the decoded upper half and the edges of the
  // current windows, so that most of the priority chain gets exercised.
  function automatic logic [15:0] pick_address();
    logic [15:0] base;
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2: base = map_cfg.ram_top;
      3: begin
        case ($urandom_range(5))
          0: base = map_cfg.scr_lo;
          1: base = map_cfg.scr_hi;
          2: base = map_cfg.col_lo;
          3: base = map_cfg.col_hi;
          4: base = map_cfg.rom_bottom;
          default: base = map_cfg.tape_base + 16'h00FF;
        endcase
      end
      4: begin
        case ($urandom_range(9))
          0: base = 16'hA000;
          1: base = 16'hC000;
          2: base = 16'hC011;
          3: base = 16'hD800;
          4: base = 16'hDE00;
          5: base = 16'hDF01;
          6: base = 16'hE7FF;
          7: base = 16'hF000;
          8: base = 16'h8000;
          default: base = 16'hA000;
        endcase
      end
      default: return 16'hC000 | 16'($urandom_range(16'h3FFF));
    endcase
    return base + 16'($urandom_range(2)) - 16'd1;
  endfunction

  function automatic logic [31:0] pick_window();
    logic [15:0] lo;
    lo = 16'hC000 + 16'($urandom_range(16'h3FFF));
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_0000;
      2: return {16'($urandom), 16'($urandom)};
      default: return {lo + 16'($urandom_range(16'h0FFF)), lo};
    endcase
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RAM_TOP: map_cfg.ram_top = val[15:0];
      REG_FEATURES: map_cfg.features = val[9:0];
      REG_MODE: map_cfg.mode = val[4:0];
      REG_SCREEN_WIN: {map_cfg.scr_hi, map_cfg.scr_lo} = val;
      REG_COLOR_WIN: {map_cfg.col_hi, map_cfg.col_lo} = val;
      REG_ROM_BOTTOM: map_cfg.rom_bottom = val[15:0];
      REG_TAPE_BASE: map_cfg.tape_base = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_access(input logic wr, input logic [15:0] a, input logic [7:0] wd,
                             input logic known, input mmad_res_t known_res);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {wd, a};
    s_axis_tuser <= wr;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_decodes.push_back(known ? known_res : decode_access(wr, a, wd));
  endtask

  task automatic drain_decoder();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_setting();
    logic [15:0] v;
    case ($urandom_range(5))
      0: v = 16'h0000;
      1: v = 16'hFFFF;
      2: v = RAM_TOP_RST;
      default: v = 16'($urandom_range(16'h9FFF));
    endcase
    write_reg(REG_RAM_TOP, {16'h0, v});
    case ($urandom_range(3))
      0: write_reg(REG_FEATURES, 32'h0);
      1: write_reg(REG_FEATURES, 32'h3FF);
      default: write_reg(REG_FEATURES, 32'($urandom_range(10'h3FF)));
    endcase
    write_reg(REG_MODE, 32'($urandom_range(31)));
    write_reg(REG_SCREEN_WIN, pick_window());
    write_reg(REG_COLOR_WIN, pick_window());
    case ($urandom_range(4))
      0: v = ROM_BOTTOM_RST;
      1: v = 16'h0000;
      2: v = 16'hFFFF;
      default: v = 16'hC000 + 16'($urandom_range(16'h3FFF));
    endcase
    write_reg(REG_ROM_BOTTOM, {16'h0, v});
    case ($urandom_range(4))
      0: v = TAPE_BASE_RST;
      1: v = 16'hFFFF;
      2: v = 16'h0000;
      default: v = 16'hC000 + 16'($urandom_range(16'h3FFF));
    endcase
    write_reg(REG_TAPE_BASE, {16'h0, v});
    // An index past the last register must leave every setting alone.
    write_reg(REG_UNUSED, $urandom);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: unexpected result beat %h, no access outstanding", $time,
                 m_axis_tdata);
        error_count++;
      end else begin
        want = pending_decodes.pop_front();
        if (m_axis_tdata[4:0] !== want.target || m_axis_tdata[20:5] !== want.offset ||
            m_axis_tdata[28:21] !== want.data || m_axis_tdata[30:29] !== want.sound_side ||
            m_axis_tdata[31] !== 1'b0) begin
          $display("%0t: expected target %0d offset %h data %h sound %0d pad 0", $time,
                   want.target, want.offset, want.data, want.sound_side);
          $display("%0t: actual   target %0d offset %h data %h sound %0d pad %b", $time,
                   m_axis_tdata[4:0], m_axis_tdata[20:5], m_axis_tdata[28:21],
                   m_axis_tdata[30:29], m_axis_tdata[31]);
          error_count++;
        end
      end
    end
  end

  initial begin
    int         ph;
    int         s;
    int         n;
    probe_row_t row;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    error_count = 0;
    cycle_count = 0;
    src_idle_pct = 18;
    sink_idle_pct = 77;
    map_cfg = '{ram_top: RAM_TOP_RST, features: FEATURES_RST, mode: 5'd0,
                scr_lo: 16'h0, scr_hi: 16'h0, col_lo: 16'h0, col_hi: 16'h0,
                rom_bottom: ROM_BOTTOM_RST, tape_base: TAPE_BASE_RST};

    // Defaults after reset: only RAM, the basic ROM, the keyboard page, kernel and tape decode.
    probe_rows.push_back(known_row(1'b0, 16'h0000, 8'h00, TGT_RAM, 16'h0000, 8'h00, SND_NONE));
    probe_rows.push_back(known_row(1'b1, 16'h9FFF, 8'hFF, TGT_RAM, 16'h9FFF, 8'hFF, SND_NONE));
    probe_rows.push_back(known_row(1'b0, 16'hA000, 8'h00, TGT_BASIC, 16'h0000, 8'h00,
                                   SND_NONE));
    probe_rows.push_back(known_row(1'b0, 16'hFFFF, 8'hFF, TGT_KERNEL, 16'h0FFF, 8'h00,
                                   SND_NONE));
    probe_rows.push_back(known_row(1'b0, 16'hC000, 8'h00, TGT_NONE, 16'hC000, 8'hC0,
                                   SND_NONE));
    probe_rows.push_back(known_row(1'b1, 16'hFFFF, 8'h5A, TGT_NONE, 16'hFFFF, 8'h5A,
                                   SND_NONE));
    probe_rows.push_back(known_row(1'b1, 16'hF000, 8'h00, TGT_TAPE, 16'hF000, 8'h00,
                                   SND_NONE));
    probe_rows.push_back(known_row(1'b0, 16'hDF01, 8'h00, TGT_KBD, 16'hDF01, 8'h00, SND_NONE));
    // Everything enabled, empty color window, kernel reaching below f000,
    // tape page at the very top.
    probe_rows.push_back(reg_row(REG_RAM_TOP, 32'h0000_7FFF));
    probe_rows.push_back(reg_row(REG_FEATURES, 32'h0000_03FF));
    probe_rows.push_back(reg_row(REG_MODE, 32'h0000_000B));
    probe_rows.push_back(reg_row(REG_SCREEN_WIN, 32'hD3FF_D000));
    probe_rows.push_back(reg_row(REG_COLOR_WIN, 32'hD400_D800));
    probe_rows.push_back(reg_row(REG_ROM_BOTTOM, 32'h0000_C100));
    probe_rows.push_back(reg_row(REG_TAPE_BASE, 32'h0000_FF80));
    probe_rows.push_back(reg_row(REG_UNUSED, 32'hFFFF_FFFF));
    probe_rows.push_back(acc_row(1'b0, 16'hC003, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'hC010, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'hD000, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'hDE00, 8'h00));
    probe_rows.push_back(acc_row(1'b1, 16'hDE00, 8'h81));
    probe_rows.push_back(acc_row(1'b0, 16'hD900, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'hE100, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'hE900, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'hC100, 8'h00));
    probe_rows.push_back(acc_row(1'b1, 16'hFFC0, 8'hA5));
    // No extra RAM, so the control ports and the 542b tone write show up.
    probe_rows.push_back(reg_row(REG_FEATURES, 32'h0000_0316));
    probe_rows.push_back(reg_row(REG_MODE, 32'h0000_000C));
    probe_rows.push_back(reg_row(REG_RAM_TOP, 32'h0000_0000));
    probe_rows.push_back(acc_row(1'b1, 16'hD800, 8'h11));
    probe_rows.push_back(acc_row(1'b1, 16'hDE00, 8'h22));
    probe_rows.push_back(acc_row(1'b1, 16'hDF01, 8'h33));
    probe_rows.push_back(acc_row(1'b0, 16'hDF01, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'h8000, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'h0000, 8'h00));
    probe_rows.push_back(acc_row(1'b0, 16'h0001, 8'h00));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (probe_rows[i]) begin
      row = probe_rows[i];
      if (row.is_cfg) begin
        drain_decoder();
        write_reg(row.reg_idx, row.reg_val);
      end else begin
        send_access(row.wr, row.addr, row.wd, row.known, row.res);
      end
    end

    for (ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct = 18;
          sink_idle_pct = 77;
        end
        1: begin
          src_idle_pct = 77;
          sink_idle_pct = 18;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (s = 0; s < SETTINGS_PER_PHASE; s++) begin
        drain_decoder();
        random_setting();
        for (n = 0; n < ACCESSES_PER_SETTING; n++) begin
          send_access(1'($urandom_range(1)), pick_address(), 8'($urandom_range(255)),
                      1'b0, '0);
        end
      end
    end

    drain_decoder();
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** memory_map_access_decoder_core: PASSED **");
    end else begin
      $display("** memory_map_access_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule
